### rtl/wildcard_glob_matcher_defines.svh
// assertion macros shared by the wildcard glob matcher checker
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// same-cycle implication, inactive during reset
`define WGM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wgm: same-cycle check failed");

// next-cycle implication, inactive during reset
`define WGM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wgm: next-cycle check failed");

// same-cycle implication that also holds through reset
`define WGM_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("wgm: reset check failed");

`endif

### rtl/wgm_pkg.sv
// types, constants and helpers of the wildcard glob matcher
package wgm_pkg;

  // default mask capacity in bytes
  localparam int MASK_MAX_DEF = 32;

  // wildcard characters
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    FN_CLEAR   = 2'd0,
    FN_APPEND  = 2'd1,
    FN_SUBJECT = 2'd2,
    FN_END     = 2'd3
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic mask_overflow;
  } out_item_t;

  // per-cycle operation strobes handed to the mask store and the position tracker
  typedef struct packed {
    logic clear;
    logic append;
    logic feed;
    logic finish;
  } wgm_ctrl_t;

  // lower A-Z when folding is enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
    logic [7:0] r;
    r = b;
    if (fold && (b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

### rtl/wgm_mask_store.sv
// mask byte registers, mask length and overflow flag, per-position compare
module wgm_mask_store import wgm_pkg::*; #(
  parameter int MASK_MAX = MASK_MAX_DEF,
  parameter int LEN_W    = $clog2(MASK_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  wgm_ctrl_t           ctrl,
  input  logic [7:0]          symbol,
  input  logic                case_fold,
  output logic [LEN_W-1:0]    mask_len,
  output logic                overflow,
  output logic [MASK_MAX-1:0] star_p,
  output logic [MASK_MAX-1:0] hit
);

  logic [7:0]          mask_byte [MASK_MAX];
  logic [MASK_MAX-1:0] is_star;
  logic [MASK_MAX-1:0] is_any;
  logic [7:0]          subj_fold;

  // length and overflow bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_len <= '0;
      overflow <= 1'b0;
    end else if (ctrl.clear) begin
      mask_len <= '0;
      overflow <= 1'b0;
    end else if (ctrl.append) begin
      if (mask_len < LEN_W'(MASK_MAX)) begin
        mask_len <= mask_len + LEN_W'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  assign subj_fold = fold_byte(symbol, case_fold);

  // one entry per mask position, written at the current length
  for (genvar i = 0; i < MASK_MAX; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (ctrl.append && (mask_len == LEN_W'(i))) begin
        mask_byte[i] <= symbol;
        is_star[i]   <= (symbol == CH_STAR);
        is_any[i]    <= (symbol == CH_QMARK);
      end
    end

    // only positions below the length take part
    always_comb begin
      logic en;
      en = (LEN_W'(i) < mask_len);
      star_p[i] = en & is_star[i];
      hit[i]    = en & ~is_star[i] &
                  (is_any[i] | (fold_byte(mask_byte[i], case_fold) == subj_fold));
    end
  end

endmodule

### rtl/wgm_nfa.sv
// active position vector with star closure and parallel advance
module wgm_nfa import wgm_pkg::*; #(
  parameter int MASK_MAX = MASK_MAX_DEF,
  parameter int LEN_W    = $clog2(MASK_MAX + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  wgm_ctrl_t           ctrl,
  input  logic [LEN_W-1:0]    mask_len,
  input  logic                overflow,
  input  logic [MASK_MAX-1:0] star_p,
  input  logic [MASK_MAX-1:0] hit,
  output logic                matched
);

  localparam int N   = MASK_MAX + 1;
  localparam int LVL = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] active;
  logic [N-1:0] active_next;
  logic [N-1:0] cur;
  logic [N-1:0] adv;
  logic [N-1:0] g [LVL+1];
  logic [N-1:0] p [LVL+1];

  // star closure as a parallel prefix: a star passes activity to the next position
  always_comb begin
    int d;
    g[0] = active;
    p[0] = {star_p, 1'b0};
    for (int l = 0; l < LVL; l++) begin
      d = 1 << l;
      for (int j = 0; j < N; j++) begin
        if (j >= d) begin
          g[l+1][j] = g[l][j] | (p[l][j] & g[l][j-d]);
          p[l+1][j] = p[l][j] & p[l][j-d];
        end else begin
          g[l+1][j] = g[l][j];
          p[l+1][j] = p[l][j];
        end
      end
    end
    cur = g[LVL];
  end

  // stars hold their position, matching bytes step one position on
  assign adv = {1'b0, cur[MASK_MAX-1:0] & star_p} | {cur[MASK_MAX-1:0] & hit, 1'b0};

  assign matched = ~overflow & cur[mask_len];

  // position vector update
  always_comb begin
    active_next = active;
    if (ctrl.clear || ctrl.finish) begin
      active_next = N'(1);
    end else if (ctrl.feed) begin
      active_next = adv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= N'(1);
    end else begin
      active <= active_next;
    end
  end

endmodule

### rtl/wildcard_glob_matcher.sv
// top level of the wildcard glob matcher
// Usage:
//   in channel  (in_valid / in_stall / in_data): one transaction per operation,
//     func selects clear mask, append mask byte, subject byte or end of subject.
//   out channel (out_valid / out_stall / out_data): one transaction per end of
//     subject, carrying matched and mask_overflow.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): case fold bit, for the user
//     to write only while the block is idle, unenforced; cfg_ready always high.
// Path: an accepted end of subject waits in the input register, is evaluated
//   from it and loaded into the result register, which raises out_valid.
// Throughput: one transaction per cycle while in_stall is low; every mask
//   position advances in parallel from the active vector, the star closure
//   being a log-depth prefix over the position vector.
// Stalls: the result register holds while out_stall is high; clear, append and
//   subject transactions keep flowing, and in_stall rises only when an end of
//   subject finds the result register still occupied and stalled.
// Reset: empty mask, no overflow, only position zero active, case fold off,
//   no result pending.
module wildcard_glob_matcher import wgm_pkg::*; #(
  parameter int MASK_MAX = MASK_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int LEN_W = $clog2(MASK_MAX + 1);

  logic                s1_valid;
  in_item_t            s1_item;
  logic                s1_go;
  wgm_ctrl_t           ctrl;
  logic                case_fold;
  logic [LEN_W-1:0]    mask_len;
  logic                overflow;
  logic [MASK_MAX-1:0] star_p;
  logic [MASK_MAX-1:0] hit;
  logic                matched;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case_fold <= cfg_data;
    end
  end

  // input register; only an end of subject waits for the result register
  assign s1_go    = s1_valid & ((s1_item.func != FN_END) | ~out_valid | ~out_stall);
  assign in_stall = s1_valid & ~s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  // decode of the registered transaction
  always_comb begin
    ctrl = '0;
    if (s1_go) begin
      case (s1_item.func)
        FN_CLEAR:   ctrl.clear  = 1'b1;
        FN_APPEND:  ctrl.append = 1'b1;
        FN_SUBJECT: ctrl.feed   = 1'b1;
        FN_END:     ctrl.finish = 1'b1;
        default:    ctrl = '0;
      endcase
    end
  end

  wgm_mask_store #(
    .MASK_MAX (MASK_MAX),
    .LEN_W    (LEN_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .symbol    (s1_item.symbol),
    .case_fold (case_fold),
    .mask_len  (mask_len),
    .overflow  (overflow),
    .star_p    (star_p),
    .hit       (hit)
  );

  wgm_nfa #(
    .MASK_MAX (MASK_MAX),
    .LEN_W    (LEN_W)
  ) u_nfa (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .mask_len (mask_len),
    .overflow (overflow),
    .star_p   (star_p),
    .hit      (hit),
    .matched  (matched)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_data.matched       <= matched;
      out_data.mask_overflow <= overflow;
    end
  end

endmodule

### rtl/wgm_checker.sv
// port-level checker for the wildcard glob matcher and its bind
`include "wildcard_glob_matcher_defines.svh"

module wgm_checker import wgm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // no result pending right after reset
  `WGM_ASSERT_RST(a_reset_empty, $fell(rst), !out_valid)

  // a stalled result transaction keeps its payload
  `WGM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // input backpressure only comes from a stalled, occupied result register
  `WGM_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)

  // an overflowed mask never reports a match
  `WGM_ASSERT_IMPL(a_ovf_no_match, out_valid && out_data.mask_overflow, !out_data.matched)

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### test/wildcard_glob_matcher_test.sv
// self-checking testbench for the wildcard glob matcher
`timescale 1ns / 100ps

module wildcard_glob_matcher_test import wgm_pkg::*;;

  localparam int MASK_CAP = MASK_MAX_DEF;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  wildcard_glob_matcher dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // transactions waiting to be driven and verdicts waiting to come out
  in_item_t  pending_items[$];
  out_item_t expected_verdicts[$];
  logic [7:0] plan_mask[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int queued = 0;
  int ends_seen = 0;
  int matches_seen = 0;
  int overflows_seen = 0;
  int results_checked = 0;

  // matcher state as the testbench sees it
  logic             fold_on = 1'b0;
  logic [7:0]       mask_bytes [MASK_CAP];
  int               mask_len = 0;
  logic [MASK_CAP:0] live_pos = (MASK_CAP + 1)'(1);
  logic             mask_dropped = 1'b0;

  out_item_t want;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [7:0] lower_letter(input logic [7:0] b);
    if (fold_on && b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

  // a star position also activates the next one without taking a byte
  function automatic logic [MASK_CAP:0] pass_stars(input logic [MASK_CAP:0] v);
    logic [MASK_CAP:0] r;
    r = v;
    for (int i = 0; i < MASK_CAP; i++) begin
      if (i < mask_len && r[i] && mask_bytes[i] == CH_STAR) begin
        r[i + 1] = 1'b1;
      end
    end
    return r;
  endfunction

  // advance the matcher state by one accepted transaction
  task automatic apply_item(input in_item_t it);
    logic [MASK_CAP:0] cur;
    logic [MASK_CAP:0] nxt;
    logic [7:0]        fc;
    out_item_t         verdict;
    case (it.func)
      FN_CLEAR: begin
        mask_len = 0;
        mask_dropped = 1'b0;
        live_pos = (MASK_CAP + 1)'(1);
      end
      FN_APPEND: begin
        if (mask_len < MASK_CAP) begin
          mask_bytes[mask_len] = it.symbol;
          mask_len++;
        end else begin
          mask_dropped = 1'b1;
        end
      end
      FN_SUBJECT: begin
        cur = pass_stars(live_pos);
        nxt = '0;
        fc = lower_letter(it.symbol);
        for (int i = 0; i < MASK_CAP; i++) begin
          if (i < mask_len && cur[i]) begin
            if (mask_bytes[i] == CH_STAR) begin
              nxt[i] = 1'b1;
            end else if (mask_bytes[i] == CH_QMARK || lower_letter(mask_bytes[i]) == fc) begin
              nxt[i + 1] = 1'b1;
            end
          end
        end
        live_pos = nxt;
      end
      default: begin
        cur = pass_stars(live_pos);
        verdict.matched = !mask_dropped && cur[mask_len];
        verdict.mask_overflow = mask_dropped;
        expected_verdicts.push_back(verdict);
        live_pos = (MASK_CAP + 1)'(1);
        ends_seen++;
        matches_seen += int'(verdict.matched);
        overflows_seen += int'(verdict.mask_overflow);
      end
    endcase
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_item(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result arrived with none expected");
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.matched !== want.matched) begin
            report_mismatch($sformatf("matched %b, expected %b", out_data.matched, want.matched));
          end
          if (out_data.mask_overflow !== want.mask_overflow) begin
            report_mismatch($sformatf("mask_overflow %b, expected %b",
                                      out_data.mask_overflow, want.mask_overflow));
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // stimulus helpers
  task automatic push_item(input func_t f, input logic [7:0] s);
    in_item_t it;
    it.func = f;
    it.symbol = s;
    pending_items.push_back(it);
    if (f == FN_CLEAR) begin
      plan_mask.delete();
    end else if (f == FN_APPEND) begin
      plan_mask.push_back(s);
    end
    queued++;
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(3))
      0: return "a";
      1: return "b";
      2: return "A";
      default: return "B";
    endcase
  endfunction

  function automatic logic [7:0] pick_mask_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return CH_STAR;
    if (r < 35) return CH_QMARK;
    if (r < 85) return pick_letter();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_subject_byte();
    if ($urandom_range(99) < 85) return pick_letter();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b | CASE_OFFSET) >= "a") && ((b | CASE_OFFSET) <= "z");
  endfunction

  // one subject, either shaped after the current mask or free, with the odd mask byte appended in between, then its end
  task automatic build_subject(input logic conform);
    logic [7:0] subj[$];
    logic [7:0] m;
    if (conform) begin
      foreach (plan_mask[i]) begin
        m = plan_mask[i];
        if (m == CH_STAR) begin
          repeat ($urandom_range(3)) subj.push_back(pick_letter());
        end else if (m == CH_QMARK) begin
          subj.push_back(8'($urandom_range(255)));
        end else if (is_letter(m) && $urandom_range(1)) begin
          subj.push_back(m ^ CASE_OFFSET);
        end else begin
          subj.push_back(m);
        end
      end
    end else begin
      repeat ($urandom_range(6)) subj.push_back(pick_subject_byte());
    end
    // occasional near misses
    if (subj.size() > 0 && $urandom_range(9) == 0) begin
      subj.delete($urandom_range(subj.size() - 1));
    end
    if ($urandom_range(9) == 0) begin
      subj.insert($urandom_range(subj.size()), pick_letter());
    end
    foreach (subj[i]) begin
      if ($urandom_range(24) == 0) begin
        push_item(FN_APPEND, pick_mask_byte());
      end
      push_item(FN_SUBJECT, subj[i]);
    end
    push_item(FN_END, 8'($urandom_range(255)));
  endtask

  // random sequences: mostly mask then subjects, some raw noise
  task automatic run_random(input int n_items);
    int first;
    int len;
    first = queued;
    while (queued - first < n_items) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(9) != 0) begin
          push_item(FN_CLEAR, 8'($urandom_range(255)));
          len = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(36, 28);
          repeat (len) push_item(FN_APPEND, pick_mask_byte());
        end
        repeat ($urandom_range(3, 1)) build_subject($urandom_range(99) < 70);
      end else begin
        repeat ($urandom_range(6, 1)) begin
          push_item(func_t'($urandom_range(3)), 8'($urandom_range(255)));
        end
      end
    end
  endtask

  // wait until every transaction is in and every verdict is out
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() > 0 || in_valid || expected_verdicts.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fold(input logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    fold_on = v;
  endtask

  // sequencer
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed cases with case fold on
    write_fold(1'b1);
    send_idle_pct = 14;
    recv_idle_pct = 49;
    push_item(FN_END, 8'h00);
    push_item(FN_SUBJECT, 8'h00);
    push_item(FN_END, 8'hFF);
    push_item(FN_APPEND, CH_STAR);
    push_item(FN_END, 8'h00);
    push_item(FN_CLEAR, 8'hFF);
    push_item(FN_APPEND, 8'hFF);
    push_item(FN_APPEND, CH_QMARK);
    push_item(FN_APPEND, "A");
    push_item(FN_SUBJECT, 8'hFF);
    push_item(FN_SUBJECT, 8'h00);
    push_item(FN_SUBJECT, "a");
    push_item(FN_END, 8'h00);
    // mask grows while a subject is in progress
    push_item(FN_SUBJECT, 8'hFF);
    push_item(FN_APPEND, CH_STAR);
    push_item(FN_SUBJECT, "x");
    push_item(FN_SUBJECT, "a");
    push_item(FN_SUBJECT, "z");
    push_item(FN_END, 8'h00);
    // text after a star must still match
    push_item(FN_CLEAR, 8'h00);
    push_item(FN_APPEND, CH_STAR);
    push_item(FN_APPEND, "b");
    push_item(FN_SUBJECT, "b");
    push_item(FN_SUBJECT, "c");
    push_item(FN_END, 8'h00);
    push_item(FN_SUBJECT, "c");
    push_item(FN_SUBJECT, "B");
    push_item(FN_END, 8'h00);
    run_random(370);
    wait_drained();

    write_fold(1'b0);
    send_idle_pct = 49;
    recv_idle_pct = 14;
    run_random(400);
    wait_drained();

    write_fold(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(300);
    wait_drained();

    write_fold(1'b0);
    run_random(300);
    wait_drained();

    $display("ran %0d transactions with case fold on and off, under sender and receiver stalls",
             queued);
    $display("checked %0d verdicts: %0d matched, %0d with an overflowed mask",
             results_checked, matches_seen, overflows_seen);
    if (errors == 0) begin
      $display("[wildcard_glob_matcher] OK");
    end else begin
      $display("[wildcard_glob_matcher] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("timeout with %0d verdicts outstanding", expected_verdicts.size());
    $display("[wildcard_glob_matcher] ERROR");
    $finish;
  end

endmodule
